@@ design/aabb_frustum_cull_macros.svh @@
// Assertion macros used by the checker module of the frustum cull block.
// Depends on nothing; included by design/afc_checker.sv.
`ifndef AABB_FRUSTUM_CULL_MACROS_SVH
`define AABB_FRUSTUM_CULL_MACROS_SVH

// Property checked on every rising edge outside of reset.
`define AFC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Property checked on every rising edge, reset included.
`define AFC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ design/afc_pkg.sv @@
// Shared types and constants of the frustum cull block.
// Depends on nothing; used by every module of the block.
package afc_pkg;

    localparam int PLANE_REGS  = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int TAG_W       = 16;
    localparam int COORD_W     = 16;
    localparam int NORM_W      = 16;
    localparam int PROD_W      = NORM_W + COORD_W;
    // Three products of at most 2^30 plus d * 2^14 stay below 2^32 in magnitude.
    localparam int SUM_W       = PROD_W + 1;
    localparam int D_SHIFT     = 14;
    localparam int PIPE_STAGES = 4;
    localparam int AXES        = 3;
    localparam int IN_TDATA_W  = TAG_W + 2 * AXES * COORD_W;
    localparam int OUT_TDATA_W = TAG_W;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [NORM_W-1:0]  t_norm;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [SUM_W-1:0]   t_sum;

    // One plane register: nx in the lowest bits, d in the highest.
    typedef struct packed {
        t_coord d;
        t_norm  nz;
        t_norm  ny;
        t_norm  nx;
    } t_plane;

    // Input beat: tag in the lowest bits.
    typedef struct packed {
        t_coord              max_z;
        t_coord              max_y;
        t_coord              max_x;
        t_coord              min_z;
        t_coord              min_y;
        t_coord              min_x;
        logic [TAG_W-1:0]    leaf_tag;
    } t_box;

    // Per-stage control of the pipeline.
    typedef struct packed {
        logic [PIPE_STAGES-1:0] load;
        logic [PIPE_STAGES-1:0] valid;
    } t_pipe_ctl;

    // True when a signed normal component is strictly positive.
    function automatic logic norm_pos(input t_norm n);
        return !n[NORM_W-1] && (|n);
    endfunction

endpackage

@@ design/afc_plane_regs.sv @@
// Plane register file written through the configuration port.
// Depends on afc_pkg.
module afc_plane_regs
    import afc_pkg::*;
#(
    parameter int PLANE_COUNT = PLANE_REGS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_plane                o_planes [PLANE_COUNT]
);

    t_plane r_plane [PLANE_COUNT];

    // Writes to an index with no stored plane are dropped.
    always_ff @(posedge i_clk) begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            if (!i_rst_n) begin
                r_plane[p] <= '0;
            end else if (i_cfg_we && (i_cfg_idx == CFG_IDX_W'(p))) begin
                r_plane[p] <= t_plane'(i_cfg_data);
            end
        end
    end

    assign o_planes = r_plane;

endmodule

@@ design/afc_pipe_ctrl.sv @@
// Valid bits and stage load enables of the cull pipeline.
// Depends on afc_pkg.
module afc_pipe_ctrl
    import afc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_pipe_ctl o_ctl
);

    logic [PIPE_STAGES-1:0] r_valid;
    logic [PIPE_STAGES-1:0] n_valid;
    logic [PIPE_STAGES:0]   stage_ready;
    logic [PIPE_STAGES-1:0] incoming;
    logic [PIPE_STAGES-1:0] load;

    // A stage takes a beat when it is empty or its beat moves on this cycle.
    always_comb begin
        stage_ready[PIPE_STAGES] = i_out_ready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
            stage_ready[k] = !r_valid[k] || stage_ready[k+1];
        end
        incoming = {r_valid[PIPE_STAGES-2:0], i_in_valid};
        load     = stage_ready[PIPE_STAGES-1:0] & incoming;
        for (int k = 0; k < PIPE_STAGES; k++) begin
            n_valid[k] = stage_ready[k] ? incoming[k] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = stage_ready[0];
    assign o_out_valid = r_valid[PIPE_STAGES-1];
    assign o_ctl.load  = load;
    assign o_ctl.valid = r_valid;

endmodule

@@ design/afc_plane_test.sv @@
// Three-stage p-vertex test of one box against one plane: multiply, partial
// sums, final sum and sign. Depends on afc_pkg.
module afc_plane_test
    import afc_pkg::*;
(
    input  logic      i_clk,
    input  t_pipe_ctl i_ctl,
    input  t_box      i_box,
    input  t_plane    i_plane,
    output logic      o_cull
);

    t_coord pick_x;
    t_coord pick_y;
    t_coord pick_z;
    t_prod  r_prod_x;
    t_prod  r_prod_y;
    t_prod  r_prod_z;
    t_coord r_d;
    t_sum   r_sum_a;
    t_sum   r_sum_b;
    t_sum   total;
    logic   r_cull;

    // Positive normal component takes the minimum, otherwise the maximum.
    assign pick_x = norm_pos(i_plane.nx) ? i_box.min_x : i_box.max_x;
    assign pick_y = norm_pos(i_plane.ny) ? i_box.min_y : i_box.max_y;
    assign pick_z = norm_pos(i_plane.nz) ? i_box.min_z : i_box.max_z;

    assign total = r_sum_a + r_sum_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_prod_x <= i_plane.nx * pick_x;
            r_prod_y <= i_plane.ny * pick_y;
            r_prod_z <= i_plane.nz * pick_z;
            r_d      <= i_plane.d;
        end
        if (i_ctl.load[1]) begin
            r_sum_a <= SUM_W'(r_prod_x) + SUM_W'(r_prod_y);
            r_sum_b <= SUM_W'(r_prod_z) + (SUM_W'(r_d) <<< D_SHIFT);
        end
        if (i_ctl.load[2]) begin
            r_cull <= !total[SUM_W-1] && (|total);
        end
    end

    assign o_cull = r_cull;

endmodule

@@ design/aabb_frustum_cull.sv @@
// Top level of the frustum cull block: AABB p-vertex test against the planes.
// Depends on afc_pkg, afc_plane_regs, afc_pipe_ctrl and afc_plane_test.
//
//  Channel   Direction  Handshake               Payload
//  ------    ---------  ---------------------   ----------------------------------
//  s_axis    in         s_axis_tvalid/tready    tdata: tag, min x/y/z, max x/y/z
//  m_axis    out        m_axis_tvalid/tready    tdata: tag; tuser: in_frustum
//  cfg       in         i_cfg_we                index i_cfg_idx, data i_cfg_data
//
// One box enters per cycle while the output is not stalled. The four stages are:
// select and multiply, two partial sums, final sum and sign, then the reduction
// across planes into the output register. Reset is synchronous and active low;
// it empties the pipeline and clears all planes to zero, which never cull. A
// stall on the output fills empty stages first and holds every beat in place,
// so ready falls only when all four stages hold beats.
module aabb_frustum_cull
    import afc_pkg::*;
#(
    parameter int PLANE_COUNT = PLANE_REGS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port, one plane register per index below PLANE_COUNT.
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Box stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0 up: leaf_tag, box_min_x, box_min_y, box_min_z,
    // box_max_x, box_max_y, box_max_z.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Result stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Fields from bit 0 up: tag_out.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // Fields from bit 0 up: in_frustum.
    output logic                   m_axis_tuser
);

    t_plane                 planes [PLANE_COUNT];
    t_pipe_ctl              ctl;
    t_box                   box;
    logic [PLANE_COUNT-1:0] cull;
    logic [TAG_W-1:0]       r_tag [PIPE_STAGES];
    logic                   r_in_frustum;

    assign box = t_box'(s_axis_tdata);

    afc_plane_regs #(
        .PLANE_COUNT (PLANE_COUNT)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_planes   (planes)
    );

    afc_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_ctl       (ctl)
    );

    // One test lane per plane; all lanes share the stage enables.
    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        afc_plane_test u_test (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_box   (box),
            .i_plane (planes[p]),
            .o_cull  (cull[p])
        );
    end

    // The tag rides alongside the arithmetic; the last stage also reduces the
    // per-plane cull flags into the result bit.
    always_ff @(posedge i_clk) begin
        if (ctl.load[0]) begin
            r_tag[0] <= box.leaf_tag;
        end
        for (int k = 1; k < PIPE_STAGES; k++) begin
            if (ctl.load[k]) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
        if (ctl.load[PIPE_STAGES-1]) begin
            r_in_frustum <= !(|cull);
        end
    end

    assign m_axis_tdata = r_tag[PIPE_STAGES-1];
    assign m_axis_tuser = r_in_frustum;

endmodule

@@ design/afc_checker.sv @@
// Port-level checker of the frustum cull block, bound to the top level.
// Depends on afc_pkg and aabb_frustum_cull_macros.svh.
`include "aabb_frustum_cull_macros.svh"

module afc_checker
    import afc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser
);

    // A reset leaves the pipeline empty.
    `AFC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

    // With the output register free or draining, every stage can move.
    `AFC_ASSERT(a_ready_when_drain, i_clk, i_rst_n, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready, "input stalled while output drains")

    // A stalled result beat stays offered.
    `AFC_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output valid dropped while stalled")

    // A stalled result beat keeps its payload.
    `AFC_ASSERT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser), "output payload changed while stalled")

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
